// File: sv/fsk_zero_crossing_bit_decoder_macros.svh
// ----------------------------------------------------------------------------
// fsk zero-crossing bit decoder assertion macros
// shared concurrent check forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef FSK_ZERO_CROSSING_BIT_DECODER_MACROS_SVH
`define FSK_ZERO_CROSSING_BIT_DECODER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FZC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FZC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/fzc_pkg.sv
// ----------------------------------------------------------------------------
// fzc_pkg
// types and fixed constants shared by the fsk zero-crossing bit decoder
// ----------------------------------------------------------------------------
`default_nettype none

package fzc_pkg;

	localparam int HISTORY_DEPTH = 4;

	localparam int TLEN_W = 8;
	localparam int ZMIN_W = 9;
	localparam int QMAX_W = 10;

	localparam logic [TLEN_W-1:0] TLEN_RESET = TLEN_W'(9 * 3);
	localparam logic [ZMIN_W-1:0] ZMIN_RESET = ZMIN_W'(18 + 18 - 5);
	localparam logic [QMAX_W-1:0] QMAX_RESET = QMAX_W'(18 + 18 + 5);

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// register index, taken from paddr word address
	typedef enum logic [1:0] {
		REG_TIMEOUT_LENGTH = 2'd0,
		REG_ZERO_PAIR_MIN  = 2'd1,
		REG_ONE_QUAD_MAX   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [TLEN_W-1:0] timeout_length;
		logic [ZMIN_W-1:0] zero_pair_min;
		logic [QMAX_W-1:0] one_quad_max;
	} cfg_t;

	typedef struct packed {
		logic bit_valid;
		logic bit_value;
		logic timed_out;
	} result_t;

endpackage

`default_nettype wire

// File: sv/fzc_cfg.sv
// ----------------------------------------------------------------------------
// fzc_cfg
// apb register file holding the decoder thresholds
// ----------------------------------------------------------------------------
`default_nettype none

module fzc_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [fzc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [fzc_pkg::DATA_W-1:0] pwdata,
	output logic      [fzc_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output fzc_pkg::cfg_t                   cfg
);

	fzc_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_length <= fzc_pkg::TLEN_RESET;
			cfg_q.zero_pair_min  <= fzc_pkg::ZMIN_RESET;
			cfg_q.one_quad_max   <= fzc_pkg::QMAX_RESET;
		end else if (wr_en) begin
			case (idx)
				fzc_pkg::REG_TIMEOUT_LENGTH: begin
					cfg_q.timeout_length <= pwdata[fzc_pkg::TLEN_W-1:0];
				end
				fzc_pkg::REG_ZERO_PAIR_MIN: begin
					cfg_q.zero_pair_min <= pwdata[fzc_pkg::ZMIN_W-1:0];
				end
				fzc_pkg::REG_ONE_QUAD_MAX: begin
					cfg_q.one_quad_max <= pwdata[fzc_pkg::QMAX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			fzc_pkg::REG_TIMEOUT_LENGTH: begin
				prdata = fzc_pkg::DATA_W'(cfg_q.timeout_length);
			end
			fzc_pkg::REG_ZERO_PAIR_MIN: begin
				prdata = fzc_pkg::DATA_W'(cfg_q.zero_pair_min);
			end
			fzc_pkg::REG_ONE_QUAD_MAX: begin
				prdata = fzc_pkg::DATA_W'(cfg_q.one_quad_max);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: sv/fzc_core.sv
// ----------------------------------------------------------------------------
// fzc_core
// input register, crossing detector, run counter, half-period history and
// bit decision, one sample per cycle unless the result buffer is full
// ----------------------------------------------------------------------------
`default_nettype none

`include "fsk_zero_crossing_bit_decoder_macros.svh"

module fzc_core #(
	parameter int COUNT_WIDTH = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            sample_neg,
	input  fzc_pkg::cfg_t        cfg,
	input  wire logic            push_ready,
	output logic                 push,
	output fzc_pkg::result_t     push_data
);

	localparam int SUM_W = (COUNT_WIDTH + 2 > fzc_pkg::QMAX_W) ?
		COUNT_WIDTH + 2 : fzc_pkg::QMAX_W;
	localparam logic [COUNT_WIDTH-1:0] RUN_MAX = {COUNT_WIDTH{1'b1}};

	// input stage
	logic valid_s1;
	logic neg_s1;

	// decoder state
	logic                   last_neg_q;
	logic [COUNT_WIDTH-1:0] run_q;
	logic [COUNT_WIDTH-1:0] hist_q [fzc_pkg::HISTORY_DEPTH];
	logic                   held_q;
	logic                   tflag_q;

	logic                   advance;
	logic                   crossing;
	logic                   timeout;
	logic [COUNT_WIDTH-1:0] shifted [fzc_pkg::HISTORY_DEPTH];
	logic [SUM_W-1:0]       pair_sum;
	logic [SUM_W-1:0]       quad_sum;
	logic                   zero_bit;
	logic                   one_bit;
	logic [COUNT_WIDTH-1:0] run_inc;

	assign advance  = valid_s1 & push_ready;
	assign in_ready = ~valid_s1 | push_ready;

	assign crossing = neg_s1 != last_neg_q;
	assign timeout  = SUM_W'(run_q) > SUM_W'(cfg.timeout_length);

	// an over-long run clears the history and enters as zero
	always_comb begin
		shifted[0] = timeout ? '0 : run_q;
		for (int i = 1; i < fzc_pkg::HISTORY_DEPTH; i++) begin
			shifted[i] = timeout ? '0 : hist_q[i-1];
		end
	end

	assign pair_sum = SUM_W'(shifted[0]) + SUM_W'(shifted[1]);
	assign quad_sum = pair_sum + SUM_W'(shifted[2]) + SUM_W'(shifted[3]);
	assign zero_bit = pair_sum >= SUM_W'(cfg.zero_pair_min);
	// a 0 bit has priority, so the quad test is gated off when the pair test passes
	assign one_bit  = ~zero_bit && (quad_sum <= SUM_W'(cfg.one_quad_max))
		&& (shifted[fzc_pkg::HISTORY_DEPTH-1] != '0);
	assign run_inc  = (run_q == RUN_MAX) ? run_q : run_q + COUNT_WIDTH'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			neg_s1   <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			neg_s1   <= sample_neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_neg_q <= 1'b0;
			run_q      <= '0;
			held_q     <= 1'b0;
			tflag_q    <= 1'b0;
			for (int i = 0; i < fzc_pkg::HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else if (advance) begin
			last_neg_q <= neg_s1;
			if (crossing) begin
				run_q   <= COUNT_WIDTH'(1);
				tflag_q <= timeout;
				if (zero_bit) begin
					held_q <= 1'b0;
				end else if (one_bit) begin
					held_q <= 1'b1;
				end
				for (int i = 0; i < fzc_pkg::HISTORY_DEPTH; i++) begin
					hist_q[i] <= (zero_bit | one_bit) ? '0 : shifted[i];
				end
			end else begin
				run_q <= run_inc;
			end
		end
	end

	always_comb begin
		push                = advance;
		push_data.bit_valid = crossing & (zero_bit | one_bit);
		push_data.timed_out = crossing ? timeout : tflag_q;
		if (crossing && zero_bit) begin
			push_data.bit_value = 1'b0;
		end else if (crossing && one_bit) begin
			push_data.bit_value = 1'b1;
		end else begin
			push_data.bit_value = held_q;
		end
	end

	`FZC_ASSERT_SAME(a_bit_needs_crossing, push && push_data.bit_valid, crossing,
		"decoded bit without a sign change")
	`FZC_ASSERT_NEXT(a_run_restarts, advance && crossing, run_q == COUNT_WIDTH'(1),
		"run counter did not restart at a crossing")
	`FZC_ASSERT_NEXT(a_run_counts, advance && !crossing && run_q != RUN_MAX,
		run_q == $past(run_q) + COUNT_WIDTH'(1), "run counter did not advance")

endmodule

`default_nettype wire

// File: sv/fzc_skid.sv
// ----------------------------------------------------------------------------
// fzc_skid
// two-entry result buffer between the decoder and the output channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "fsk_zero_crossing_bit_decoder_macros.svh"

module fzc_skid (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  fzc_pkg::result_t  push_data,
	output logic              push_ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	output fzc_pkg::result_t  out_data
);

	fzc_pkg::result_t slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             pop;

	assign out_valid  = count_q != 2'd0;
	assign push_ready = count_q != 2'd2;
	assign pop        = out_valid & out_ready;
	assign out_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`FZC_ASSERT_SAME(a_no_push_when_full, push, push_ready,
		"item pushed into a full result buffer")
	`FZC_ASSERT_SAME(a_count_range, 1'b1, count_q != 2'd3,
		"result buffer count out of range")
	`FZC_ASSERT_NEXT(a_pop_drains, pop && !push, count_q == $past(count_q) - 2'd1,
		"result buffer count did not drop after a pop")

endmodule

`default_nettype wire

// File: sv/fsk_zero_crossing_bit_decoder.sv
// ----------------------------------------------------------------------------
// fsk_zero_crossing_bit_decoder
// cassette fsk demodulator: counts samples between sign changes and decodes
// low-tone pairs as 0 bits and high-tone quads as 1 bits
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries one signed sample per item; only
//   its sign bit is looked at. output channel out_valid/out_ready returns one
//   result item per sample: bit_valid, the held bit value and the timeout flag.
//   thresholds sit in three apb registers at byte addresses 0, 4 and 8
//   (timeout length, zero pair minimum, one quad maximum); write them only
//   while no items are in flight.
// timing
//   a sample is captured in the input register, then its result is written
//   into the result buffer, which raises out_valid. throughput is one item
//   per cycle while the result buffer has room, as the decoder stage updates
//   the run counter and four-entry history as each sample advances.
// reset and stall
//   arst_n restores the register defaults and clears the run counter, history,
//   held bit and timeout flag. when out_ready is low the two-entry result
//   buffer takes up to two more results and one more item waits in the input
//   register before in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module fsk_zero_crossing_bit_decoder #(
	parameter int COUNT_WIDTH = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [fzc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [fzc_pkg::DATA_W-1:0] pwdata,
	output logic      [fzc_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [15:0]         sample,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            bit_valid,
	output logic                            bit_value,
	output logic                            timed_out
);

	fzc_pkg::cfg_t    cfg;
	fzc_pkg::result_t push_data;
	fzc_pkg::result_t out_data;
	logic             push;
	logic             push_ready;

	fzc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fzc_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_neg (sample[15]),
		.cfg        (cfg),
		.push_ready (push_ready),
		.push       (push),
		.push_data  (push_data)
	);

	fzc_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	assign bit_valid = out_data.bit_valid;
	assign bit_value = out_data.bit_value;
	assign timed_out = out_data.timed_out;

endmodule

`default_nettype wire

// File: sim/fsk_zero_crossing_bit_decoder_tb.sv
// ----------------------------------------------------------------------------
// fsk_zero_crossing_bit_decoder_tb
// drives signed samples through the decoder, runs a bit-level model of the
// run counter, four-entry history and tone tests alongside, and compares
// every result item field by field over several threshold settings and
// random source and sink stalls
// ----------------------------------------------------------------------------
module fsk_zero_crossing_bit_decoder_tb;

	localparam int STALL_LIMIT   = 2000;
	localparam int SEGMENT_ITEMS = 115;
	localparam int N_SEGMENTS    = 6;
	localparam int N_ROWS        = 15;
	localparam logic [7:0] RUN_MAX = 8'hff;

	typedef struct {
		logic signed [15:0] value;
		int                 repeats;
		bit                 typed;
		fzc_pkg::result_t   want;
	} stim_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [fzc_pkg::ADDR_W-1:0]  paddr;
	logic [fzc_pkg::DATA_W-1:0]  pwdata;
	logic [fzc_pkg::DATA_W-1:0]  prdata;
	logic                        pready;
	logic                        in_valid;
	logic                        in_ready;
	logic signed [15:0]          sample;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic                        bit_valid;
	logic                        bit_value;
	logic                        timed_out;

	// decoder model state
	fzc_pkg::cfg_t thresholds;
	bit            last_neg;
	logic [7:0]    run_len;
	logic [7:0]    half_period [fzc_pkg::HISTORY_DEPTH];
	bit            held_bit;
	bit            timeout_seen;

	fzc_pkg::result_t results_due [$];
	stim_row_t        directed_rows [N_ROWS];
	int               fail_count;
	int               idle_cycles;
	int               send_idle_pct;
	int               recv_idle_pct;
	bit               send_neg;

	fsk_zero_crossing_bit_decoder uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_history();
		foreach (half_period[i])
			half_period[i] = '0;
	endfunction

	function automatic void reset_decoder_model();
		thresholds.timeout_length = fzc_pkg::TLEN_RESET;
		thresholds.zero_pair_min  = fzc_pkg::ZMIN_RESET;
		thresholds.one_quad_max   = fzc_pkg::QMAX_RESET;
		last_neg     = 1'b0;
		run_len      = '0;
		held_bit     = 1'b0;
		timeout_seen = 1'b0;
		clear_history();
	endfunction

	function automatic fzc_pkg::result_t decode_sample(logic signed [15:0] value);
		fzc_pkg::result_t r;
		logic [7:0]       run;
		int               pair_sum;
		int               quad_sum;
		bit               neg;
		neg = value[15];
		r.bit_valid = 1'b0;
		if (neg != last_neg) begin
			run = run_len;
			if (run > thresholds.timeout_length) begin
				clear_history();
				run = '0;
				timeout_seen = 1'b1;
			end else begin
				timeout_seen = 1'b0;
			end
			for (int i = fzc_pkg::HISTORY_DEPTH - 1; i > 0; i--)
				half_period[i] = half_period[i-1];
			half_period[0] = run;
			run_len = '0;
			pair_sum = int'(half_period[0]) + int'(half_period[1]);
			if (pair_sum >= int'(thresholds.zero_pair_min)) begin
				held_bit = 1'b0;
				r.bit_valid = 1'b1;
				clear_history();
			end
			// a 0 bit has already emptied entry 3, so the quad test cannot also fire
			quad_sum = 0;
			foreach (half_period[i])
				quad_sum += int'(half_period[i]);
			if (quad_sum <= int'(thresholds.one_quad_max) &&
					half_period[fzc_pkg::HISTORY_DEPTH-1] != 0) begin
				held_bit = 1'b1;
				r.bit_valid = 1'b1;
				clear_history();
			end
		end
		if (run_len < RUN_MAX)
			run_len++;
		last_neg = neg;
		r.bit_value = held_bit;
		r.timed_out = timeout_seen;
		return r;
	endfunction

	function automatic void check_field(string field, logic want, logic got);
		if (want !== got) begin
			fail_count++;
			$error("%s: expected %0b, actual %0b", field, want, got);
		end
	endfunction

	function automatic logic signed [15:0] tone_sample(bit neg);
		case ($urandom_range(15))
			0: return neg ? 16'sh8000 : 16'sh7fff;
			1: return neg ? -16'sd1 : 16'sd0;
			default: return {neg, 15'($urandom)};
		endcase
	endfunction

	function automatic int pick_run_length();
		int pick;
		pick = $urandom_range(199);
		if (pick < 80)
			return $urandom_range(3, 7);    // high tone
		else if (pick < 150)
			return $urandom_range(12, 20);  // low tone
		else if (pick < 180)
			return $urandom_range(1, 3);    // noise
		else if (pick < 199)
			return $urandom_range(21, 80);  // dropout, mostly timeouts
		else
			return $urandom_range(240, 300); // long run, saturating the counter from 255 up
	endfunction

	// called on a rising edge; returns on the edge at which the item is taken
	task automatic send_sample(input logic signed [15:0] value, input bit typed = 1'b0,
			input fzc_pkg::result_t want = '0);
		fzc_pkg::result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= value;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = decode_sample(value);
		results_due.push_back(typed ? want : predicted);
	endtask

	task automatic send_run(input int len);
		repeat (len)
			send_sample(tone_sample(send_neg));
		send_neg = ~send_neg;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input fzc_pkg::reg_idx_t idx,
			input logic [fzc_pkg::DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= fzc_pkg::ADDR_W'(4 * int'(idx));
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			fzc_pkg::REG_TIMEOUT_LENGTH:
				thresholds.timeout_length = data[fzc_pkg::TLEN_W-1:0];
			fzc_pkg::REG_ZERO_PAIR_MIN:
				thresholds.zero_pair_min  = data[fzc_pkg::ZMIN_W-1:0];
			fzc_pkg::REG_ONE_QUAD_MAX:
				thresholds.one_quad_max   = data[fzc_pkg::QMAX_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_thresholds(input logic [fzc_pkg::DATA_W-1:0] tlen,
			input logic [fzc_pkg::DATA_W-1:0] zmin, input logic [fzc_pkg::DATA_W-1:0] qmax);
		wait_drained();
		write_reg(fzc_pkg::REG_TIMEOUT_LENGTH, tlen);
		write_reg(fzc_pkg::REG_ZERO_PAIR_MIN, zmin);
		write_reg(fzc_pkg::REG_ONE_QUAD_MAX, qmax);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// sink side: stalls, result checks and the no-progress watchdog
	always @(posedge clk) begin
		fzc_pkg::result_t want;
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					fail_count++;
					$error("result item with nothing expected");
				end else begin
					want = results_due.pop_front();
					check_field("bit_valid", want.bit_valid, bit_valid);
					check_field("bit_value", want.bit_value, bit_value);
					check_field("timed_out", want.timed_out, timed_out);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int len;
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		in_valid = 1'b0;
		sample   = '0;
		fail_count    = 0;
		idle_cycles   = 0;
		send_idle_pct = 35;
		recv_idle_pct = 48;
		send_neg      = 1'b1;
		reset_decoder_model();

		directed_rows = '{
			// first item after reset: no crossing, all flags clear
			'{16'sd100,   1,   1'b1, '{1'b0, 1'b0, 1'b0}},
			'{16'sh7fff,  1,   1'b0, '{1'b0, 1'b0, 1'b0}},
			'{16'sh8000,  1,   1'b0, '{1'b0, 1'b0, 1'b0}},
			// high tone, short half-periods
			'{16'sd0,     4,   1'b0, '{1'b0, 1'b0, 1'b0}},
			'{-16'sd1,    4,   1'b0, '{1'b0, 1'b0, 1'b0}},
			'{16'sd0,     4,   1'b0, '{1'b0, 1'b0, 1'b0}},
			'{-16'sd1,    4,   1'b0, '{1'b0, 1'b0, 1'b0}},
			// low tone, long half-periods
			'{16'sd0,     16,  1'b0, '{1'b0, 1'b0, 1'b0}},
			'{-16'sd1,    16,  1'b0, '{1'b0, 1'b0, 1'b0}},
			'{16'sd0,     16,  1'b0, '{1'b0, 1'b0, 1'b0}},
			// over-long run then a crossing
			'{16'sh8000,  40,  1'b0, '{1'b0, 1'b0, 1'b0}},
			'{16'sh7fff,  1,   1'b0, '{1'b0, 1'b0, 1'b0}},
			// run counter saturation
			'{16'sh1234,  300, 1'b0, '{1'b0, 1'b0, 1'b0}},
			'{16'shedcb,  1,   1'b0, '{1'b0, 1'b0, 1'b0}},
			'{16'sh5a5a,  1,   1'b0, '{1'b0, 1'b0, 1'b0}}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			repeat (directed_rows[i].repeats)
				send_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);

		for (int seg = 0; seg < N_SEGMENTS; seg++) begin
			case (seg)
				0: set_thresholds(32'd254, 32'd510, 32'd1020);
				1: set_thresholds(32'd0, 32'd0, 32'd0);
				// bits above each register width must be dropped
				2: set_thresholds(32'hffff_ffff, 32'hffff_fe1f, 32'habcd_ffff);
				3: set_thresholds(fzc_pkg::DATA_W'(fzc_pkg::TLEN_RESET),
						fzc_pkg::DATA_W'(fzc_pkg::ZMIN_RESET),
						fzc_pkg::DATA_W'(fzc_pkg::QMAX_RESET));
				4: set_thresholds($urandom_range(20, 60), $urandom_range(16, 40),
						$urandom_range(24, 60));
				default: set_thresholds($urandom_range(254), $urandom_range(510),
						$urandom_range(1020));
			endcase
			send_idle_pct = (seg < 2) ? 35 : (seg < 4) ? 48 : 0;
			recv_idle_pct = (seg < 2) ? 48 : (seg < 4) ? 35 : 0;
			sent = 0;
			while (sent < SEGMENT_ITEMS) begin
				len = pick_run_length();
				send_run(len);
				sent += len;
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/fzc_pkg.sv
sv/fzc_cfg.sv
sv/fzc_core.sv
sv/fzc_skid.sv
sv/fsk_zero_crossing_bit_decoder.sv
sim/fsk_zero_crossing_bit_decoder_tb.sv
